>>> hdl/fat_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// fat_block_allocator_defines
// assertion macros used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FAT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FAT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// types and codes of the file allocation table block allocator
// ----------------------------------------------------------------------------
package fba_pkg;

    typedef logic [15:0] t_link;

    // link values
    localparam t_link LINK_FREE = 16'h0000;
    localparam t_link LINK_END  = 16'hFFFF;

    // span of a block index
    localparam logic [16:0] INDEX_SPAN = 17'd8192;
    localparam int unsigned ENTRIES_PER_TABLE_BLOCK = 2048;

    // operation kinds
    localparam logic [2:0] KIND_ALLOC      = 3'd0;
    localparam logic [2:0] KIND_ALLOC_LINK = 3'd1;
    localparam logic [2:0] KIND_FREE_CHAIN = 3'd2;
    localparam logic [2:0] KIND_COUNT_FREE = 3'd3;
    localparam logic [2:0] KIND_WRITE      = 3'd4;
    localparam logic [2:0] KIND_READ       = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic CFG_ENTRY_LIMIT = 1'b0;
    localparam logic CFG_DATA_BLOCKS = 1'b1;

    // register reset values
    localparam logic [13:0] ENTRY_LIMIT_RESET = 14'(4 * ENTRIES_PER_TABLE_BLOCK);
    localparam logic [13:0] DATA_BLOCKS_RESET = 14'd8192;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_LINK_WR  = 4'd3;
    localparam logic [3:0] S_END_WR   = 4'd4;
    localparam logic [3:0] S_COUNT    = 4'd5;
    localparam logic [3:0] S_FREE_RD  = 4'd6;
    localparam logic [3:0] S_FREE_CHK = 4'd7;
    localparam logic [3:0] S_RD_WAIT  = 4'd8;

endpackage

>>> hdl/fat_block_allocator.sv
// ----------------------------------------------------------------------------
// fat_block_allocator
// operations: a write finishes at once, a read waits for the registered table read,
//   allocate scans for the first free index (writing the link first when linking),
//   count free scans up to its bound, free chain walks until an end mark or a free entry
// throughput: one item at a time, set by the single table memory port pair
// reset: synchronous; a clearing pass zeroes the table, busy stays high for it,
//   config writes are taken throughout
// ----------------------------------------------------------------------------
`include "fat_block_allocator_defines.svh"

module fat_block_allocator
    import fba_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [12:0] i_block,
    input  logic [15:0] i_value,
    // result strobe and fields
    output logic        o_done,
    output logic [12:0] o_block_index,
    output logic [15:0] o_entry_value,
    output logic [13:0] o_free_count,
    output logic [1:0]  o_status,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);
    localparam logic [16:0] DEPTH_LAST = 17'(TABLE_DEPTH - 1);

    // link table memory, one write and one registered read per cycle
    t_link   mem [TABLE_DEPTH];
    logic    mem_we;
    logic [AW-1:0] mem_wa;
    t_link   mem_wd;
    logic    mem_re;
    logic [AW-1:0] mem_ra;
    t_link   r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // sequencer state
    logic [3:0]  r_state, n_state;
    logic [2:0]  r_kind, n_kind;
    logic [12:0] r_block, n_block;
    logic [16:0] r_idx, n_idx;      // scan, clear or chain walk position
    logic        r_pv, n_pv;        // a scan read is in flight
    logic [13:0] r_pa, n_pa;        // address of the read in flight
    logic [12:0] r_found, n_found;
    logic [13:0] r_count, n_count;

    // configuration registers
    logic [13:0] r_limit;
    logic [13:0] r_dbc;

    // result registers
    logic        r_done, n_done;
    logic [12:0] r_out_index, n_out_index;
    logic [15:0] r_out_value, n_out_value;
    logic [13:0] r_out_count, n_out_count;
    logic [1:0]  r_out_status, n_out_status;

    // search bounds
    logic [16:0] bound_alloc;
    logic [16:0] bound_cnt;
    logic [16:0] lim_w;
    logic [16:0] dbc_w;
    logic [16:0] lim_d;
    logic [16:0] in_blk_w;
    logic [16:0] blk_w;
    logic [16:0] found_w;

    always_comb begin
        lim_w = {3'b000, r_limit};
        dbc_w = {3'b000, r_dbc};
        lim_d = (lim_w < DEPTH_W) ? lim_w : DEPTH_W;
        bound_alloc = (lim_d < INDEX_SPAN) ? lim_d : INDEX_SPAN;
        bound_cnt = (dbc_w < DEPTH_W) ? dbc_w : DEPTH_W;
        in_blk_w = {4'b0000, i_block};
        blk_w = {4'b0000, r_block};
        found_w = {4'b0000, r_found};
    end

    always_comb begin
        n_state = r_state;
        n_kind = r_kind;
        n_block = r_block;
        n_idx = r_idx;
        n_pv = r_pv;
        n_pa = r_pa;
        n_found = r_found;
        n_count = r_count;
        n_done = 1'b0;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_count = r_out_count;
        n_out_status = r_out_status;
        mem_we = 1'b0;
        mem_wa = r_idx[AW-1:0];
        mem_wd = LINK_FREE;
        mem_re = 1'b0;
        mem_ra = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_kind;
                    n_block = i_block;
                    n_idx = '0;
                    n_pv = 1'b0;
                    n_count = '0;
                    // results that need no table walk are filled in here
                    n_out_index = '0;
                    n_out_value = '0;
                    n_out_count = '0;
                    n_out_status = ST_OK;
                    unique case (i_kind)
                        KIND_ALLOC: begin
                            n_state = S_SCAN;
                        end
                        KIND_ALLOC_LINK: begin
                            if (in_blk_w >= DEPTH_W) begin
                                n_done = 1'b1;
                                n_out_status = ST_RANGE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        KIND_FREE_CHAIN: begin
                            n_idx = in_blk_w;
                            n_state = S_FREE_RD;
                        end
                        KIND_COUNT_FREE: begin
                            n_state = S_COUNT;
                        end
                        KIND_WRITE: begin
                            n_done = 1'b1;
                            if (in_blk_w >= DEPTH_W) begin
                                n_out_status = ST_RANGE;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = in_blk_w[AW-1:0];
                                mem_wd = i_value;
                            end
                        end
                        KIND_READ: begin
                            if (in_blk_w >= DEPTH_W) begin
                                n_done = 1'b1;
                                n_out_status = ST_RANGE;
                            end else begin
                                mem_re = 1'b1;
                                mem_ra = in_blk_w[AW-1:0];
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            // unused kinds report zeros
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                // post-reset sweep zeroes one entry per cycle
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = LINK_FREE;
                n_idx = r_idx + 17'd1;
                if (r_idx == DEPTH_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // first-fit search, one read issued per cycle
                if (r_pv && (r_rdata == LINK_FREE)) begin
                    n_found = r_pa[12:0];
                    n_pv = 1'b0;
                    n_state = (r_kind == KIND_ALLOC_LINK) ? S_LINK_WR : S_END_WR;
                end else if (r_idx >= bound_alloc) begin
                    n_pv = 1'b0;
                    n_done = 1'b1;
                    n_out_index = '0;
                    n_out_status = ST_FULL;
                    n_state = S_IDLE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_idx[AW-1:0];
                    n_pa = r_idx[13:0];
                    n_pv = 1'b1;
                    n_idx = r_idx + 17'd1;
                end
            end
            S_LINK_WR: begin
                // link goes in before the end mark
                mem_we = 1'b1;
                mem_wa = blk_w[AW-1:0];
                mem_wd = {3'b000, r_found};
                n_state = S_END_WR;
            end
            S_END_WR: begin
                mem_we = 1'b1;
                mem_wa = found_w[AW-1:0];
                mem_wd = LINK_END;
                n_done = 1'b1;
                n_out_index = r_found;
                n_out_status = ST_OK;
                n_state = S_IDLE;
            end
            S_COUNT: begin
                if (r_pv && (r_rdata == LINK_FREE)) begin
                    n_count = r_count + 14'd1;
                end
                if (r_idx >= bound_cnt) begin
                    n_pv = 1'b0;
                    n_done = 1'b1;
                    n_out_count = n_count;
                    n_out_status = ST_OK;
                    n_state = S_IDLE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_idx[AW-1:0];
                    n_pa = r_idx[13:0];
                    n_pv = 1'b1;
                    n_idx = r_idx + 17'd1;
                end
            end
            S_FREE_RD: begin
                if (r_idx == {1'b0, LINK_END}) begin
                    n_done = 1'b1;
                    n_out_status = ST_OK;
                    n_state = S_IDLE;
                end else if (r_idx >= DEPTH_W) begin
                    n_done = 1'b1;
                    n_out_status = ST_RANGE;
                    n_state = S_IDLE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_idx[AW-1:0];
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                // a free entry ends the walk, which also breaks cycles
                if (r_rdata == LINK_FREE) begin
                    n_done = 1'b1;
                    n_out_status = ST_OK;
                    n_state = S_IDLE;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_idx[AW-1:0];
                    mem_wd = LINK_FREE;
                    n_idx = {1'b0, r_rdata};
                    n_state = S_FREE_RD;
                end
            end
            S_RD_WAIT: begin
                n_done = 1'b1;
                n_out_value = r_rdata;
                n_out_status = ST_OK;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= '0;
            r_pv <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_pv <= n_pv;
            r_done <= n_done;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_block <= n_block;
        r_pa <= n_pa;
        r_found <= n_found;
        r_count <= n_count;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_count <= n_out_count;
        r_out_status <= n_out_status;
    end

    // configuration registers, writable at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ENTRY_LIMIT_RESET;
            r_dbc <= DATA_BLOCKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENTRY_LIMIT: r_limit <= i_cfg_data;
                CFG_DATA_BLOCKS: r_dbc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_block_index = r_out_index;
    assign o_entry_value = r_out_value;
    assign o_free_count = r_out_count;
    assign o_status = r_out_status;

    // a result strobe only ever shows with the sequencer back at idle
    `FBA_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, !busy, "result while busy")
    // an accepted item either finishes at once or keeps the block busy
    `FBA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || r_done,
        "accepted item lost")
    // table writes stay inside the table
    `FBA_ASSERT_NOW(a_write_range, i_clk, i_rst_n, mem_we, {{(17-AW){1'b0}}, mem_wa} < DEPTH_W,
        "table write out of range")
    // a scan read in flight never lies at or beyond the scan position
    `FBA_ASSERT_NOW(a_scan_order, i_clk, i_rst_n, r_pv, {3'b000, r_pa} < r_idx,
        "scan read ahead of position")

endmodule
